// ----- design/sfls_pkg.sv -----
// ---------------------------------------------------------------------------
// sfls_pkg: shared types and constants for the substring first/last search
// Sizes of the pattern store and the position counter, operation codes,
// and the result word passed from the search core to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sfls_pkg;

  // Longest pattern held, and the width of text positions.
  localparam int MAX_PAT  = 32;
  localparam int POS_BITS = 16;

  // Pattern length counts 0..MAX_PAT.
  localparam int PLEN_W = $clog2(MAX_PAT + 1);

  // Width used when a position is compared against the pattern length.
  localparam int CMP_W = ((POS_BITS + 1) > PLEN_W) ? (POS_BITS + 1) : PLEN_W;

  // Width of the position fields on the result channel.
  localparam int OUT_W = 16;

  typedef logic [7:0]          byte_t;
  typedef logic [PLEN_W-1:0]   plen_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [CMP_W-1:0]    cmp_t;
  typedef logic [OUT_W-1:0]    out_pos_t;

  // Saturation value of the text position counter.
  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PAT   = 2'd1,
    OP_TEXT  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  // Result of an end word, as the core computes it.
  typedef struct packed {
    pos_t first;
    pos_t last;
    logic found;
    logic overflow;
  } res_t;

endpackage

`default_nettype wire

// ----- design/sfls_match.sv -----
// ---------------------------------------------------------------------------
// sfls_match: parallel window compare
// Compares every entry of the text window with the pattern entry at the
// same place and reports a hit when all entries below the pattern length
// agree.
// ---------------------------------------------------------------------------
`default_nettype none

module sfls_match (
  input  sfls_pkg::byte_t pat    [sfls_pkg::MAX_PAT],
  input  sfls_pkg::byte_t win    [sfls_pkg::MAX_PAT],
  input  sfls_pkg::plen_t plen,
  output logic            hit
);

  logic [sfls_pkg::MAX_PAT-1:0] ok;

  // Each entry either matches or lies beyond the pattern and is ignored.
  always_comb begin
    for (int k = 0; k < sfls_pkg::MAX_PAT; k++) begin
      ok[k] = (pat[k] == win[k]) || (sfls_pkg::cmp_t'(k) >= sfls_pkg::cmp_t'(plen));
    end
  end

  assign hit = &ok;

endmodule

`default_nettype wire

// ----- design/sfls_core.sv -----
// ---------------------------------------------------------------------------
// sfls_core: search state and per-word update
// Holds the pattern, the text window, the text counter and the match record.
// One word is executed per enabled cycle; an end word's result is produced
// combinationally for the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfls_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              exec_en,
  input  sfls_pkg::op_t     op,
  input  sfls_pkg::byte_t   ch,
  output sfls_pkg::res_t    res
);

  // The pattern is kept newest first, so entry k lines up with window entry k.
  sfls_pkg::byte_t pat_r   [sfls_pkg::MAX_PAT];
  sfls_pkg::byte_t win_r   [sfls_pkg::MAX_PAT];
  sfls_pkg::byte_t win_nxt [sfls_pkg::MAX_PAT];

  sfls_pkg::plen_t plen_r, plen_nxt;
  sfls_pkg::pos_t  count_r, count_nxt;
  sfls_pkg::pos_t  first_r, first_nxt;
  sfls_pkg::pos_t  last_r, last_nxt;
  logic            seen_r, seen_nxt;
  logic            ovf_r, ovf_nxt;
  logic            tover_r, tover_nxt;
  logic            pat_load;
  logic            win_load;
  logic            clear;
  logic            hit;

  sfls_pkg::pos_t  count_inc;
  logic            count_sat;
  sfls_pkg::pos_t  start_pos;
  sfls_pkg::cmp_t  start_wide;
  logic            long_enough;
  logic            matched;

  // Window after the current text byte is shifted in.
  always_comb begin
    win_nxt[0] = ch;
    for (int k = 1; k < sfls_pkg::MAX_PAT; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  sfls_match u_match (
    .pat  (pat_r),
    .win  (win_nxt),
    .plen (plen_r),
    .hit  (hit)
  );

  // Text counter saturation and match start position.
  always_comb begin
    count_sat   = (count_r == sfls_pkg::POS_MAX);
    count_inc   = count_sat ? count_r : count_r + sfls_pkg::pos_t'(1);
    long_enough = sfls_pkg::cmp_t'(count_inc) >= sfls_pkg::cmp_t'(plen_r);
    start_wide  = sfls_pkg::cmp_t'(count_inc) - sfls_pkg::cmp_t'(plen_r)
                  + sfls_pkg::cmp_t'(1);
    start_pos   = (tover_r || count_sat) ? sfls_pkg::POS_MAX
                                         : start_wide[sfls_pkg::POS_BITS-1:0];
    matched     = hit && (plen_r != '0) && long_enough;
  end

  // Next-state logic for one executed word.
  always_comb begin
    plen_nxt  = plen_r;
    count_nxt = count_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    tover_nxt = tover_r;
    pat_load  = 1'b0;
    win_load  = 1'b0;
    clear     = 1'b0;
    if (exec_en) begin
      case (op)
        sfls_pkg::OP_START: begin
          clear     = 1'b1;
          plen_nxt  = '0;
          count_nxt = '0;
          first_nxt = '0;
          last_nxt  = '0;
          seen_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          tover_nxt = 1'b0;
        end
        sfls_pkg::OP_PAT: begin
          // Pattern bytes count only before any text has arrived.
          if (count_r == '0 && !tover_r) begin
            if (sfls_pkg::cmp_t'(plen_r) >= sfls_pkg::cmp_t'(sfls_pkg::MAX_PAT)) begin
              ovf_nxt = 1'b1;
            end else begin
              pat_load = 1'b1;
              plen_nxt = plen_r + sfls_pkg::plen_t'(1);
            end
          end
        end
        sfls_pkg::OP_TEXT: begin
          win_load  = 1'b1;
          count_nxt = count_inc;
          if (count_sat) begin
            tover_nxt = 1'b1;
            ovf_nxt   = 1'b1;
          end
          if (matched) begin
            if (!seen_r) begin
              first_nxt = start_pos;
            end
            last_nxt = start_pos;
            seen_nxt = 1'b1;
          end
        end
        default: begin
          // An end word leaves the state as it is.
        end
      endcase
    end
  end

  // Control and match record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      count_r <= '0;
      first_r <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      tover_r <= 1'b0;
    end else begin
      plen_r  <= plen_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      tover_r <= tover_nxt;
    end
  end

  // Text window shift line, cleared by reset and by a start word.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int k = 0; k < sfls_pkg::MAX_PAT; k++) begin
        win_r[k] <= '0;
      end
    end else if (win_load) begin
      for (int k = 0; k < sfls_pkg::MAX_PAT; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // Pattern shift line; only entries below the pattern length are compared.
  always_ff @(posedge clk) begin
    if (pat_load) begin
      pat_r[0] <= ch;
      for (int k = 1; k < sfls_pkg::MAX_PAT; k++) begin
        pat_r[k] <= pat_r[k-1];
      end
    end
  end

  // Result of an end word, taken from the current state.
  always_comb begin
    if (plen_r == '0) begin
      res.first = (count_r != '0) ? sfls_pkg::pos_t'(1) : '0;
      res.last  = (tover_r || count_sat) ? sfls_pkg::POS_MAX
                                         : count_r + sfls_pkg::pos_t'(1);
    end else begin
      res.first = first_r;
      res.last  = last_r;
    end
    res.found    = (res.first != '0) || (res.last != '0);
    res.overflow = ovf_r;
  end

endmodule

`default_nettype wire

// ----- design/substring_first_last_search.sv -----
// ---------------------------------------------------------------------------
// substring_first_last_search: first and last match of a pattern in a text
// Streams pattern and text words, compares the window of recent text bytes
// with the pattern on every text byte and reports the first and last match
// start on each end word.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  in_operation, in_char_value
//   out_      output     out_valid/out_stall out_first_position, out_last_position,
//                                           out_found, out_overflow
//
// One word is accepted per cycle while in_stall is low; each word executes in
// the input register stage after it is accepted, and an end word's result
// is captured from there into the output register.
// The rate is set by the combinational window compare of the search core.
// Reset clears all control state and the text window.
// Only an end word waits while an earlier result is stalled on the output;
// then in_stall rises until the output register is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module substring_first_last_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_first_position,
  output logic [15:0] out_last_position,
  output logic        out_found,
  output logic        out_overflow
);

  logic              in_v_r;
  sfls_pkg::op_t     op_r;
  sfls_pkg::byte_t   ch_r;
  logic              hold;
  logic              exec_en;
  logic              exec_end;
  logic              in_take;
  sfls_pkg::res_t    res;

  logic              out_v_r, out_v_nxt;
  sfls_pkg::out_pos_t first_r;
  sfls_pkg::out_pos_t last_r;
  logic              found_r;
  logic              ovf_r;

  // An end word waits while the output register holds a stalled result.
  assign hold     = in_v_r && (op_r == sfls_pkg::OP_END) && out_v_r && out_stall;
  assign in_stall = hold;
  assign in_take  = in_valid && !hold;
  assign exec_en  = in_v_r && !hold;
  assign exec_end = exec_en && (op_r == sfls_pkg::OP_END);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!hold) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= sfls_pkg::op_t'(in_operation);
      ch_r <= in_char_value;
    end
  end

  sfls_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (exec_en),
    .op      (op_r),
    .ch      (ch_r),
    .res     (res)
  );

  // Output register.
  always_comb begin
    out_v_nxt = out_v_r && out_stall;
    if (exec_end) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_end) begin
      first_r <= sfls_pkg::out_pos_t'(res.first);
      last_r  <= sfls_pkg::out_pos_t'(res.last);
      found_r <= res.found;
      ovf_r   <= res.overflow;
    end
  end

  assign out_valid          = out_v_r;
  assign out_first_position = first_r;
  assign out_last_position  = last_r;
  assign out_found          = found_r;
  assign out_overflow       = ovf_r;

`ifndef SYNTH
  // A new result only appears after an end word has executed.
  a_out_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(exec_end))
    else $error("result word without an executed end word");

  // The input side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result is never overwritten by a new end word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !exec_end)
    else $error("stalled result overwritten");

  // The found flag agrees with the reported positions.
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == ((out_first_position != 16'd0) ||
                                 (out_last_position != 16'd0))))
    else $error("found flag disagrees with positions");
`endif

endmodule

`default_nettype wire
